FILE: rtl/core/prss_pkg.sv
// Package for the priority slice round robin scheduler: payload structs,
// slot status and function codes, controller states and datapath commands.
// Used by every module of the block; depends on nothing.
package prss_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

  // Configuration register indexes.
  localparam logic [2:0] CFG_ENABLE = 3'd0;
  localparam logic [2:0] CFG_HIGH   = 3'd1;
  localparam logic [2:0] CFG_NORMAL = 3'd2;
  localparam logic [2:0] CFG_LOW    = 3'd3;
  localparam logic [2:0] CFG_IDLE   = 3'd4;

  // Function codes of a request.
  localparam logic [2:0] FN_TICK      = 3'd0;
  localparam logic [2:0] FN_YIELD     = 3'd1;
  localparam logic [2:0] FN_CREATE    = 3'd2;
  localparam logic [2:0] FN_SET_PRIO  = 3'd3;
  localparam logic [2:0] FN_TERMINATE = 3'd4;

  // Result status codes.
  localparam logic [1:0] RS_OK        = 2'd0;
  localparam logic [1:0] RS_FULL      = 2'd1;
  localparam logic [1:0] RS_NOT_FOUND = 2'd2;

  // Priority codes.
  localparam logic [1:0] PR_IDLE   = 2'd0;
  localparam logic [1:0] PR_LOW    = 2'd1;
  localparam logic [1:0] PR_NORMAL = 2'd2;
  localparam logic [1:0] PR_HIGH   = 2'd3;

  typedef enum logic [1:0] {
    SL_FREE    = 2'd0,
    SL_READY   = 2'd1,
    SL_RUNNING = 2'd2
  } slot_state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  prio;
    logic [15:0] target_pid;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  run_slot;
    logic [15:0] run_pid;
    logic        switched;
    logic [15:0] new_pid;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_TICK, S_SW_INIT, S_SW_TEST, S_SET_RUN,
    S_T_INIT, S_T_PRED, S_T_FREE, S_T_WALK,
    S_CR_SCAN, S_CR_LINK, S_SP_SCAN, S_SP_WRITE, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_TICK, OP_SW_INIT, OP_SW_TEST, OP_SET_RUN,
    OP_T_INIT, OP_T_PRED, OP_T_FREE, OP_T_WALK,
    OP_CR_SCAN, OP_CR_LINK, OP_SP_SCAN, OP_SP_WRITE, OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       en;
    logic       hit;
    logic       last;
    logic       single;
    logic       out_busy;
  } stat_t;

  // Base slice for a priority.
  function automatic logic [3:0] slice_for(input logic [1:0] p, input logic [3:0] hi,
                                           input logic [3:0] nm, input logic [3:0] lo,
                                           input logic [3:0] id);
    logic [3:0] s;
    case (p)
      PR_HIGH:   s = hi;
      PR_NORMAL: s = nm;
      PR_LOW:    s = lo;
      default:   s = id;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/prss_ctrl.sv
// Controller state machine of the scheduler: sequences each request as
// datapath commands. Depends on prss_pkg.
module prss_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  prss_pkg::stat_t stat,
  output prss_pkg::cmd_t  cmd
);

  prss_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prss_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prss_pkg::S_IDLE: begin
        if (in_valid) state_nxt = prss_pkg::S_DISPATCH;
      end
      prss_pkg::S_DISPATCH: begin
        case (stat.func)
          prss_pkg::FN_TICK:      state_nxt = stat.en ? prss_pkg::S_TICK : prss_pkg::S_DONE;
          prss_pkg::FN_YIELD:     state_nxt = stat.en ? prss_pkg::S_SW_INIT : prss_pkg::S_DONE;
          prss_pkg::FN_CREATE:    state_nxt = prss_pkg::S_CR_SCAN;
          prss_pkg::FN_SET_PRIO:  state_nxt = prss_pkg::S_SP_SCAN;
          prss_pkg::FN_TERMINATE: state_nxt = stat.en ? prss_pkg::S_T_INIT : prss_pkg::S_DONE;
          default:                state_nxt = prss_pkg::S_DONE;
        endcase
      end
      prss_pkg::S_TICK:    state_nxt = stat.hit ? prss_pkg::S_SW_INIT : prss_pkg::S_DONE;
      prss_pkg::S_SW_INIT: state_nxt = prss_pkg::S_SW_TEST;
      prss_pkg::S_SW_TEST: begin
        if (stat.hit || stat.last) state_nxt = prss_pkg::S_SET_RUN;
      end
      prss_pkg::S_SET_RUN: state_nxt = prss_pkg::S_DONE;
      prss_pkg::S_T_INIT:  state_nxt = stat.single ? prss_pkg::S_DONE : prss_pkg::S_T_PRED;
      prss_pkg::S_T_PRED: begin
        if (stat.hit || stat.last) state_nxt = prss_pkg::S_T_FREE;
      end
      prss_pkg::S_T_FREE:  state_nxt = prss_pkg::S_T_WALK;
      prss_pkg::S_T_WALK: begin
        if (stat.hit || stat.last) state_nxt = prss_pkg::S_SET_RUN;
      end
      prss_pkg::S_CR_SCAN: begin
        if (stat.hit) state_nxt = prss_pkg::S_CR_LINK;
        else if (stat.last) state_nxt = prss_pkg::S_DONE;
      end
      prss_pkg::S_CR_LINK: state_nxt = prss_pkg::S_DONE;
      prss_pkg::S_SP_SCAN: begin
        if (stat.hit) state_nxt = prss_pkg::S_SP_WRITE;
        else if (stat.last) state_nxt = prss_pkg::S_DONE;
      end
      prss_pkg::S_SP_WRITE: state_nxt = prss_pkg::S_DONE;
      prss_pkg::S_DONE: begin
        if (!stat.out_busy) state_nxt = prss_pkg::S_IDLE;
      end
      default: state_nxt = prss_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = prss_pkg::OP_NONE;
    case (state_r)
      prss_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = prss_pkg::OP_LOAD;
      end
      prss_pkg::S_TICK:     cmd.op = prss_pkg::OP_TICK;
      prss_pkg::S_SW_INIT:  cmd.op = prss_pkg::OP_SW_INIT;
      prss_pkg::S_SW_TEST:  cmd.op = prss_pkg::OP_SW_TEST;
      prss_pkg::S_SET_RUN:  cmd.op = prss_pkg::OP_SET_RUN;
      prss_pkg::S_T_INIT:   cmd.op = prss_pkg::OP_T_INIT;
      prss_pkg::S_T_PRED:   cmd.op = prss_pkg::OP_T_PRED;
      prss_pkg::S_T_FREE:   cmd.op = prss_pkg::OP_T_FREE;
      prss_pkg::S_T_WALK:   cmd.op = prss_pkg::OP_T_WALK;
      prss_pkg::S_CR_SCAN:  cmd.op = prss_pkg::OP_CR_SCAN;
      prss_pkg::S_CR_LINK:  cmd.op = prss_pkg::OP_CR_LINK;
      prss_pkg::S_SP_SCAN:  cmd.op = prss_pkg::OP_SP_SCAN;
      prss_pkg::S_SP_WRITE: cmd.op = prss_pkg::OP_SP_WRITE;
      prss_pkg::S_DONE: begin
        if (!stat.out_busy) cmd.op = prss_pkg::OP_OUT;
      end
      default: cmd.op = prss_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: rtl/core/prss_dpath.sv
// Datapath of the scheduler: slot table, ring links, walk pointer,
// configuration registers and result register. Depends on prss_pkg.
module prss_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  prss_pkg::in_item_t  in_data,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [3:0]          cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output prss_pkg::out_item_t out_data,
  input  prss_pkg::cmd_t      cmd,
  output prss_pkg::stat_t     stat
);

  localparam int W = prss_pkg::SLOT_W;
  localparam int N = prss_pkg::SLOT_COUNT;

  prss_pkg::slot_state_t st_r [N];
  logic [15:0]  pid_r  [N];
  logic [1:0]   prio_r [N];
  logic [3:0]   base_r [N];
  logic [3:0]   left_r [N];
  logic [W-1:0] link_r [N];

  logic [W-1:0] cur_r, ptr_r, aux_r, k_r;
  logic [15:0]  pid_ctr_r;
  logic         found_r;
  prss_pkg::in_item_t req_r;
  logic         en_r;
  logic [3:0]   sl_hi_r, sl_nm_r, sl_lo_r, sl_id_r;
  logic         out_valid_r;
  prss_pkg::out_item_t out_r;
  logic         res_sw_r;
  logic [15:0]  res_pid_r;
  logic [1:0]   res_st_r;

  logic [W-1:0] rd_idx;
  prss_pkg::slot_state_t rd_st;
  logic [W-1:0] rd_link;
  logic         rd_live;
  logic [3:0]   req_slice;

  // One table read per cycle, at the current slot or at the walk pointer.
  always_comb begin
    case (cmd.op)
      prss_pkg::OP_TICK, prss_pkg::OP_SW_INIT, prss_pkg::OP_T_INIT,
      prss_pkg::OP_CR_LINK, prss_pkg::OP_OUT: rd_idx = cur_r;
      default: rd_idx = ptr_r;
    endcase
  end

  assign rd_st     = st_r[rd_idx];
  assign rd_link   = link_r[rd_idx];
  assign rd_live   = (rd_st == prss_pkg::SL_READY) || (rd_st == prss_pkg::SL_RUNNING);
  assign req_slice = prss_pkg::slice_for(req_r.prio, sl_hi_r, sl_nm_r, sl_lo_r, sl_id_r);

  // Status back to the controller.
  always_comb begin
    stat.func     = req_r.func;
    stat.en       = en_r;
    stat.single   = (rd_link == cur_r);
    stat.out_busy = out_valid_r && !out_ready;
    stat.last     = (k_r == prss_pkg::SLOT_LAST);
    case (cmd.op)
      prss_pkg::OP_TICK:    stat.hit = (left_r[rd_idx] <= 4'd1);
      prss_pkg::OP_SW_TEST: stat.hit = rd_live || (ptr_r == aux_r);
      prss_pkg::OP_T_PRED:  stat.hit = (rd_link == cur_r);
      prss_pkg::OP_T_WALK:  stat.hit = rd_live;
      prss_pkg::OP_CR_SCAN: begin
        stat.hit  = (rd_st == prss_pkg::SL_FREE);
        stat.last = (ptr_r == prss_pkg::SLOT_LAST);
      end
      prss_pkg::OP_SP_SCAN: begin
        stat.hit  = (rd_st != prss_pkg::SL_FREE) && (pid_r[rd_idx] == req_r.target_pid);
        stat.last = (ptr_r == prss_pkg::SLOT_LAST);
      end
      default: stat.hit = 1'b0;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b0;
      sl_hi_r <= 4'd4;
      sl_nm_r <= 4'd2;
      sl_lo_r <= 4'd1;
      sl_id_r <= 4'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        prss_pkg::CFG_ENABLE: en_r    <= cfg_data[0];
        prss_pkg::CFG_HIGH:   sl_hi_r <= cfg_data;
        prss_pkg::CFG_NORMAL: sl_nm_r <= cfg_data;
        prss_pkg::CFG_LOW:    sl_lo_r <= cfg_data;
        prss_pkg::CFG_IDLE:   sl_id_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Slot table, walk registers and result, driven by the command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        st_r[i]   <= (i == 0) ? prss_pkg::SL_RUNNING : prss_pkg::SL_FREE;
        pid_r[i]  <= 16'd0;
        prio_r[i] <= (i == 0) ? prss_pkg::PR_NORMAL : prss_pkg::PR_IDLE;
        base_r[i] <= (i == 0) ? 4'd2 : 4'd0;
        left_r[i] <= (i == 0) ? 4'd2 : 4'd0;
        link_r[i] <= W'(i);
      end
      cur_r       <= '0;
      ptr_r       <= '0;
      aux_r       <= '0;
      k_r         <= '0;
      found_r     <= 1'b0;
      pid_ctr_r   <= 16'd1;
      out_valid_r <= 1'b0;
      res_sw_r    <= 1'b0;
      res_pid_r   <= 16'd0;
      res_st_r    <= prss_pkg::RS_OK;
    end else begin
      // A taken result is cleared unless a new one is loaded in its place.
      if (out_valid_r && out_ready && (cmd.op != prss_pkg::OP_OUT)) out_valid_r <= 1'b0;
      case (cmd.op)
        prss_pkg::OP_LOAD: begin
          req_r     <= in_data;
          res_sw_r  <= 1'b0;
          res_pid_r <= 16'd0;
          res_st_r  <= prss_pkg::RS_OK;
          k_r       <= '0;
          ptr_r     <= (in_data.func == prss_pkg::FN_CREATE) ? W'(1) : '0;
        end
        prss_pkg::OP_TICK: begin
          if (left_r[rd_idx] != 4'd0) left_r[rd_idx] <= left_r[rd_idx] - 4'd1;
        end
        prss_pkg::OP_SW_INIT: begin
          left_r[rd_idx] <= base_r[rd_idx];
          if (rd_st == prss_pkg::SL_RUNNING) st_r[rd_idx] <= prss_pkg::SL_READY;
          ptr_r    <= rd_link;
          aux_r    <= cur_r;
          k_r      <= '0;
          res_sw_r <= 1'b1;
        end
        prss_pkg::OP_SW_TEST, prss_pkg::OP_T_WALK: begin
          if (!stat.hit) begin
            if (stat.last) begin
              ptr_r <= aux_r;
            end else begin
              ptr_r <= rd_link;
              k_r   <= k_r + W'(1);
            end
          end
        end
        prss_pkg::OP_SET_RUN: begin
          cur_r        <= ptr_r;
          st_r[ptr_r]  <= prss_pkg::SL_RUNNING;
        end
        prss_pkg::OP_T_INIT: begin
          res_sw_r <= 1'b1;
          aux_r    <= rd_link;
          ptr_r    <= rd_link;
          k_r      <= '0;
          found_r  <= 1'b0;
          if (rd_link == cur_r) begin
            left_r[rd_idx] <= base_r[rd_idx];
            st_r[rd_idx]   <= prss_pkg::SL_RUNNING;
          end
        end
        prss_pkg::OP_T_PRED: begin
          if (stat.hit) begin
            found_r <= 1'b1;
          end else if (!stat.last) begin
            ptr_r <= rd_link;
            k_r   <= k_r + W'(1);
          end
        end
        prss_pkg::OP_T_FREE: begin
          if (found_r) link_r[ptr_r] <= aux_r;
          link_r[cur_r] <= cur_r;
          st_r[cur_r]   <= prss_pkg::SL_FREE;
          pid_r[cur_r]  <= 16'd0;
          prio_r[cur_r] <= prss_pkg::PR_IDLE;
          base_r[cur_r] <= 4'd0;
          left_r[cur_r] <= 4'd0;
          ptr_r         <= aux_r;
          k_r           <= '0;
        end
        prss_pkg::OP_CR_SCAN: begin
          if (!stat.hit) begin
            if (stat.last) res_st_r <= prss_pkg::RS_FULL;
            else ptr_r <= ptr_r + W'(1);
          end
        end
        prss_pkg::OP_CR_LINK: begin
          res_pid_r     <= pid_ctr_r;
          pid_ctr_r     <= pid_ctr_r + 16'd1;
          pid_r[ptr_r]  <= pid_ctr_r;
          st_r[ptr_r]   <= prss_pkg::SL_READY;
          prio_r[ptr_r] <= req_r.prio;
          base_r[ptr_r] <= req_slice;
          left_r[ptr_r] <= req_slice;
          link_r[ptr_r] <= rd_link;
          link_r[cur_r] <= ptr_r;
        end
        prss_pkg::OP_SP_SCAN: begin
          if (!stat.hit) begin
            if (stat.last) res_st_r <= prss_pkg::RS_NOT_FOUND;
            else ptr_r <= ptr_r + W'(1);
          end
        end
        prss_pkg::OP_SP_WRITE: begin
          prio_r[ptr_r] <= req_r.prio;
          base_r[ptr_r] <= req_slice;
        end
        prss_pkg::OP_OUT: begin
          out_valid_r    <= 1'b1;
          out_r.run_slot <= 4'(cur_r);
          out_r.run_pid  <= pid_r[rd_idx];
          out_r.switched <= res_sw_r;
          out_r.new_pid  <= res_pid_r;
          out_r.status   <= res_st_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/core/priority_slice_round_robin_scheduler.sv
// Top level of the priority slice round robin scheduler.
// Instantiates prss_ctrl and prss_dpath; depends on prss_pkg.
//
// One request is handled at a time and gives one result. A create or a set
// priority scans the slot table, one slot scanned a cycle; a switch is set
// by the ring walk that follows one link a cycle, and a terminate walks the
// ring twice. The next request can be accepted in the following cycle after
// the result register is loaded, while the finished result waits in the
// output register; a result that has not been taken holds back the one
// after it. Configuration writes are taken in any cycle.
module priority_slice_round_robin_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prss_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prss_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [3:0]          cfg_data
);

  prss_pkg::cmd_t  cmd;
  prss_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  prss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  prss_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

FILE: rtl/core/prss_checker.sv
// Port checker for the scheduler, bound to the top level.
// Depends on prss_pkg and priority_slice_round_robin_scheduler.
module prss_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input prss_pkg::out_item_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only the three defined status codes appear.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == prss_pkg::RS_OK ||
                   out_data.status == prss_pkg::RS_FULL ||
                   out_data.status == prss_pkg::RS_NOT_FOUND))
    else $error("undefined status code");

  // A switching request neither creates nor fails.
  a_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.switched |->
      out_data.status == prss_pkg::RS_OK && out_data.new_pid == 16'd0)
    else $error("switch with create result");

  // A failed request gives no new pid.
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != prss_pkg::RS_OK |-> out_data.new_pid == 16'd0)
    else $error("new pid on failed request");

  // A request is never accepted in the cycle after another one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("back to back requests accepted");

endmodule

bind priority_slice_round_robin_scheduler prss_checker u_prss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
